### hdl/ppls_pkg.sv
// shared constants, formats and arctangent table for the line steering pipeline
package ppls_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ANG_SHIFT = 30 - FRAC_BITS;

    // datapath widths
    localparam int CW    = 38;   // cordic x/y
    localparam int ZW    = 36;   // cordic angle, q30 radians
    localparam int KW    = 24;   // gain correction constant
    localparam int SPW   = 21;   // speed
    localparam int HDW   = 20;   // heading
    localparam int PW    = 32;   // positions and rate
    localparam int REGW  = 20;   // lookahead registers
    localparam int DW    = 33;   // position differences
    localparam int NUMW  = 39;   // divider dividend
    localparam int QW    = 32;   // divider quotient
    localparam int SNW   = 32;   // sine, q30
    localparam int MW    = SPW + SNW;

    localparam int GF_SHIFT = 24;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_GAIN = 2'd0,
        REG_MIN  = 2'd1,
        REG_MAX  = 2'd2
    } reg_idx_t;

    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [ZW-1:0] FOUR_PI_Q30 = 36'sd13493037704;
    localparam logic [KW-1:0]        INVK_Q24    = 24'd10187995;
    localparam logic signed [CW-1:0] ONE_Q30     = 38'sd1073741824;
    localparam logic signed [CW-1:0] SIN_EPS_Q30 = 38'sd1074;

    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:  a = 36'sd843314857;
            1:  a = 36'sd497837829;
            2:  a = 36'sd263043837;
            3:  a = 36'sd133525159;
            4:  a = 36'sd67021687;
            5:  a = 36'sd33543516;
            6:  a = 36'sd16775851;
            7:  a = 36'sd8388437;
            8:  a = 36'sd4194283;
            9:  a = 36'sd2097149;
            10: a = 36'sd1048576;
            11: a = 36'sd524288;
            12: a = 36'sd262144;
            13: a = 36'sd131072;
            14: a = 36'sd65536;
            15: a = 36'sd32768;
            16: a = 36'sd16384;
            17: a = 36'sd8192;
            18: a = 36'sd4096;
            19: a = 36'sd2048;
            20: a = 36'sd1024;
            21: a = 36'sd512;
            22: a = 36'sd256;
            23: a = 36'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### hdl/ppls_gain_fix.sv
// two-stage cordic gain correction, multiply by 1/K in q24 with round half up
module ppls_gain_fix (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ppls_pkg::CW-1:0] v,
    output logic signed [ppls_pkg::CW-1:0] r
);
    import ppls_pkg::*;

    localparam int LW = 18;
    localparam int HW = CW - LW;
    localparam int SW = 64;

    logic [LW-1:0]          lo;
    logic signed [HW-1:0]   hi;
    logic [LW+KW-1:0]       plo_reg;
    logic signed [HW+KW:0]  phi_reg;
    logic signed [SW-1:0]   sum;
    logic signed [CW-1:0]   r_reg;

    assign lo = v[LW-1:0];
    assign hi = v[CW-1:LW];

    // partial products on the low and high halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= lo * INVK_Q24;
            phi_reg <= hi * $signed({1'b0, INVK_Q24});
        end
    end

    assign sum = ($signed({{(SW-(HW+KW+1)){phi_reg[HW+KW]}}, phi_reg}) <<< LW)
               + $signed({{(SW-(LW+KW)){1'b0}}, plo_reg})
               + ($signed(SW'(1)) <<< (GF_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= CW'(sum >>> GF_SHIFT);
        end
    end

    assign r = r_reg;

endmodule

### hdl/ppls_cordic_vec.sv
// pipelined vectoring cordic: magnitude and angle of a vector
module ppls_cordic_vec #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [ppls_pkg::CW-1:0] x_in,
    input  logic signed [ppls_pkg::CW-1:0] y_in,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_vld,
    output logic signed [ppls_pkg::CW-1:0] mag,
    output logic signed [ppls_pkg::ZW-1:0] ang,
    output logic [SIDE_W-1:0]              side_out
);
    import ppls_pkg::*;

    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic [SIDE_W-1:0]    side_reg [0:STAGES];
    logic                 vld_reg [0:STAGES];
    logic signed [ZW-1:0] z_d1_reg, z_d2_reg;
    logic [SIDE_W-1:0]    side_d1_reg, side_d2_reg;
    logic                 vld_d1_reg, vld_d2_reg;

    // fold the left half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            if (x_in[CW-1])
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= y_in[CW-1] ? -PI_Q30 : PI_Q30;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = atan_q30(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    ppls_gain_fix u_gain (
        .clk (clk),
        .en  (en),
        .v   (x_reg[STAGES]),
        .r   (mag)
    );

    // angle and sideband wait for the gain correction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_d1_reg    <= z_reg[STAGES];
            z_d2_reg    <= z_d1_reg;
            side_d1_reg <= side_reg[STAGES];
            side_d2_reg <= side_d1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d1_reg <= 1'b0;
            vld_d2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_d1_reg <= vld_reg[STAGES];
            vld_d2_reg <= vld_d1_reg;
        end
    end

    assign ang      = z_d2_reg;
    assign side_out = side_d2_reg;
    assign out_vld  = vld_d2_reg;

endmodule

### hdl/ppls_cordic_rot.sv
// pipelined rotation cordic: rotate a vector by an angle
module ppls_cordic_rot #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic signed [ppls_pkg::CW-1:0] x_in,
    input  logic signed [ppls_pkg::CW-1:0] y_in,
    input  logic signed [ppls_pkg::ZW-1:0] z_in,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           out_vld,
    output logic signed [ppls_pkg::CW-1:0] x_out,
    output logic signed [ppls_pkg::CW-1:0] y_out,
    output logic [SIDE_W-1:0]              side_out
);
    import ppls_pkg::*;

    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic [SIDE_W-1:0]    side_reg [0:STAGES];
    logic                 vld_reg [0:STAGES];
    logic [SIDE_W-1:0]    side_d1_reg, side_d2_reg;
    logic                 vld_d1_reg, vld_d2_reg;

    // fold angles beyond a quarter turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            if (z_in > HALF_PI_Q30)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= z_in - PI_Q30;
            end
            else if (z_in < -HALF_PI_Q30)
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= z_in + PI_Q30;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= z_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = atan_q30(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    ppls_gain_fix u_gain_x (
        .clk (clk),
        .en  (en),
        .v   (x_reg[STAGES]),
        .r   (x_out)
    );

    ppls_gain_fix u_gain_y (
        .clk (clk),
        .en  (en),
        .v   (y_reg[STAGES]),
        .r   (y_out)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d1_reg <= side_reg[STAGES];
            side_d2_reg <= side_d1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d1_reg <= 1'b0;
            vld_d2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_d1_reg <= vld_reg[STAGES];
            vld_d2_reg <= vld_d1_reg;
        end
    end

    assign side_out = side_d2_reg;
    assign out_vld  = vld_d2_reg;

endmodule

### hdl/ppls_divider.sv
// pipelined restoring divider, one quotient bit per stage, msb first
module ppls_divider #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [ppls_pkg::NUMW-1:0]   num,
    input  logic [ppls_pkg::REGW-1:0]   den,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_vld,
    output logic [ppls_pkg::QW-1:0]     quo,
    output logic [SIDE_W-1:0]           side_out
);
    import ppls_pkg::*;

    localparam int RW = REGW + QW;

    logic [NUMW-1:0]   rem_reg  [0:QW];
    logic [REGW-1:0]   den_reg  [0:QW];
    logic [QW-1:0]     q_reg    [0:QW];
    logic [SIDE_W-1:0] side_reg [0:QW];
    logic              vld_reg  [0:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        localparam int K = QW - 1 - j;
        logic [RW-1:0] sh;
        logic [RW-1:0] rem_w;
        logic          ge;

        assign sh    = RW'(den_reg[j]) << K;
        assign rem_w = RW'(rem_reg[j]);
        assign ge    = (rem_w >= sh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? NUMW'(rem_w - sh) : rem_reg[j];
                den_reg[j+1]  <= den_reg[j];
                q_reg[j+1]    <= {q_reg[j][QW-2:0], ge};
                side_reg[j+1] <= side_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end
    end

    assign quo      = q_reg[QW];
    assign side_out = side_reg[QW];
    assign out_vld  = vld_reg[QW];

endmodule

### hdl/pure_pursuit_line_steering_top.sv
// top level of the pure-pursuit line steering pipeline
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  input    | in_valid / in_stall          | speed, pos_x, pos_y, heading, start/end x,y
//  output   | out_valid / out_stall        | speed_out, turn_rate, degenerate_segment
//  config   | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// one request enters per cycle while the pipeline is not stalled; each request passes through
// five cordic pipelines (each CORDIC_STAGES + 3 deep) and the 33-stage divider
// reset clears all valid bits and loads the lookahead registers with their defaults
// a stalled result freezes the whole pipeline in place; nothing is dropped or repeated
// cfg_ready is always high; writes to an unused index are ignored
module pure_pursuit_line_steering_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [ppls_pkg::SPW-1:0]   speed,
    input  logic signed [ppls_pkg::PW-1:0]    pos_x,
    input  logic signed [ppls_pkg::PW-1:0]    pos_y,
    input  logic signed [ppls_pkg::HDW-1:0]   heading,
    input  logic signed [ppls_pkg::PW-1:0]    start_x,
    input  logic signed [ppls_pkg::PW-1:0]    start_y,
    input  logic signed [ppls_pkg::PW-1:0]    end_x,
    input  logic signed [ppls_pkg::PW-1:0]    end_y,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ppls_pkg::SPW-1:0]   speed_out,
    output logic signed [ppls_pkg::PW-1:0]    turn_rate,
    output logic                              degenerate_segment,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [ppls_pkg::REGW-1:0]         cfg_data
);
    import ppls_pkg::*;

    // sideband carried alongside the cordic and divider pipelines
    typedef struct packed {
        logic signed [SPW-1:0] speed;
        logic signed [HDW-1:0] hd;
        logic signed [DW-1:0]  vx;
        logic signed [DW-1:0]  vy;
        logic [REGW-1:0]       ld;
        logic                  degen;
    } side_a_t;

    typedef struct packed {
        side_a_t              a;
        logic signed [CW-1:0] len;
        logic signed [ZW-1:0] phi;
    } side_b_t;

    typedef struct packed {
        logic signed [SPW-1:0] speed;
        logic signed [HDW-1:0] hd;
        logic [REGW-1:0]       ld;
        logic                  degen;
        logic                  wzero;
    } side_c_t;

    typedef struct packed {
        logic signed [SPW-1:0] speed;
        logic [REGW-1:0]       ld;
        logic                  degen;
    } side_d_t;

    typedef struct packed {
        logic signed [SPW-1:0] speed;
        logic                  degen;
        logic                  tiny;
        logic                  ldz;
        logic                  speedz;
        logic                  ovf;
        logic                  neg;
    } side_e_t;

    localparam int SA_W = $bits(side_a_t);
    localparam int SB_W = $bits(side_b_t);
    localparam int SC_W = $bits(side_c_t);
    localparam int SD_W = $bits(side_d_t);
    localparam int SE_W = $bits(side_e_t);
    localparam int PPW  = REGW + SPW + 1;
    localparam int LQW  = PPW - FRAC_BITS;

    localparam logic signed [PW-1:0] RATE_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] RATE_MIN = {1'b1, {(PW-1){1'b0}}};

    // global advance: the pipeline moves unless a finished result is held
    logic adv;

    // configuration registers
    logic [REGW-1:0] gain_reg, min_reg, max_reg;

    // stage 0: differences and gain product
    logic                  s0_valid_reg;
    logic signed [SPW-1:0] s0_speed_reg;
    logic signed [HDW-1:0] s0_hd_reg;
    logic signed [DW-1:0]  s0_dx_reg, s0_dy_reg, s0_vx_reg, s0_vy_reg;
    logic signed [PPW-1:0] s0_p_reg;

    logic signed [LQW-1:0] pq;
    logic [REGW-1:0]       ld_next;
    side_a_t               vec1_side_in;

    logic                  vec1_vld;
    logic signed [CW-1:0]  vec1_mag;
    logic signed [ZW-1:0]  vec1_ang;
    logic [SA_W-1:0]       vec1_side_raw;
    side_a_t               vec1_side;
    side_b_t               rot1_side_in;

    logic                  rot1_vld;
    logic signed [CW-1:0]  rot1_x, rot1_y;
    logic [SB_W-1:0]       rot1_side_raw;
    side_b_t               rot1_side;

    // stage c: clamp the projection and step ahead by the lookahead
    logic                  sc_valid_reg;
    logic signed [CW-1:0]  sc_s_reg;
    logic signed [ZW-1:0]  sc_phi_reg;
    side_a_t               sc_side_reg;
    logic signed [CW-1:0]  along_c;
    logic signed [CW-1:0]  sc_s_next;

    logic                  rot2_vld;
    logic signed [CW-1:0]  rot2_x, rot2_y;
    logic [SA_W-1:0]       rot2_side_raw;
    side_a_t               rot2_side;

    // stage d: offset from robot to target
    logic                  sd_valid_reg;
    logic signed [CW-1:0]  sd_wx_reg, sd_wy_reg;
    side_a_t               sd_side_reg;
    side_c_t               vec2_side_in;

    logic                  vec2_vld;
    logic signed [CW-1:0]  vec2_mag;
    logic signed [ZW-1:0]  vec2_ang;
    logic [SC_W-1:0]       vec2_side_raw;
    side_c_t               vec2_side;

    // stage e/f: heading error and wrap
    logic                  se_valid_reg;
    logic signed [ZW-1:0]  se_alpha_reg;
    side_c_t               se_side_reg;
    logic signed [ZW-1:0]  theta_c;
    logic signed [ZW-1:0]  hd_q30;

    logic                  sf_valid_reg;
    logic signed [ZW-1:0]  sf_alpha_reg;
    side_d_t               sf_side_reg;
    logic signed [ZW-1:0]  alpha_m1, alpha_m2, alpha_p1, alpha_p2, alpha_w;
    side_d_t               sf_side_next;

    logic                  rot3_vld;
    logic signed [CW-1:0]  rot3_x, rot3_y;
    logic [SD_W-1:0]       rot3_side_raw;
    side_d_t               rot3_side;

    // stage g: small-sine test and numerator product
    logic                  sg_valid_reg;
    logic signed [MW-1:0]  sg_m_reg;
    logic                  sg_tiny_reg;
    logic                  sg_neg_reg;
    side_d_t               sg_side_reg;
    logic signed [SNW-1:0] sn;

    logic [MW-1:0]         m_abs;
    logic [NUMW-1:0]       div_num;
    logic                  ovf;
    side_e_t               div_side_in;

    logic                  div_vld;
    logic [QW-1:0]         div_q;
    logic [SE_W-1:0]       div_side_raw;
    side_e_t               div_side;

    // output register
    logic                  out_valid_reg;
    logic signed [SPW-1:0] speed_out_reg;
    logic signed [PW-1:0]  turn_rate_reg;
    logic                  degen_reg;
    logic signed [PW-1:0]  rate_next;

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 20'd19661;
            min_reg  <= 20'd19661;
            max_reg  <= 20'd131072;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN: gain_reg <= cfg_data;
                REG_MIN:  min_reg  <= cfg_data;
                REG_MAX:  max_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    // stage 0
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_speed_reg <= speed;
            s0_hd_reg    <= heading;
            s0_dx_reg    <= DW'(end_x) - DW'(start_x);
            s0_dy_reg    <= DW'(end_y) - DW'(start_y);
            s0_vx_reg    <= DW'(pos_x) - DW'(start_x);
            s0_vy_reg    <= DW'(pos_y) - DW'(start_y);
            s0_p_reg     <= $signed({1'b0, gain_reg}) * speed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    // lookahead clamp; when the limits cross, values below min give min and all others give max
    assign pq = LQW'(s0_p_reg >>> FRAC_BITS);

    always_comb
    begin
        if (pq < $signed({1'b0, min_reg}))
        begin
            ld_next = min_reg;
        end
        else if (pq > $signed({1'b0, max_reg}))
        begin
            ld_next = max_reg;
        end
        else
        begin
            ld_next = pq[REGW-1:0];
        end
    end

    always_comb
    begin
        vec1_side_in.speed = s0_speed_reg;
        vec1_side_in.hd    = s0_hd_reg;
        vec1_side_in.vx    = s0_vx_reg;
        vec1_side_in.vy    = s0_vy_reg;
        vec1_side_in.ld    = ld_next;
        vec1_side_in.degen = (s0_dx_reg == '0) && (s0_dy_reg == '0);
    end

    // segment length and direction
    ppls_cordic_vec #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SA_W)
    ) u_vec_seg (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s0_valid_reg),
        .x_in     (CW'(s0_dx_reg)),
        .y_in     (CW'(s0_dy_reg)),
        .side_in  (vec1_side_in),
        .out_vld  (vec1_vld),
        .mag      (vec1_mag),
        .ang      (vec1_ang),
        .side_out (vec1_side_raw)
    );

    assign vec1_side = side_a_t'(vec1_side_raw);

    always_comb
    begin
        rot1_side_in.a   = vec1_side;
        rot1_side_in.len = vec1_mag;
        rot1_side_in.phi = vec1_ang;
    end

    // project the robot onto the segment axis
    ppls_cordic_rot #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SB_W)
    ) u_rot_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (vec1_vld),
        .x_in     (CW'(vec1_side.vx)),
        .y_in     (CW'(vec1_side.vy)),
        .z_in     (-vec1_ang),
        .side_in  (rot1_side_in),
        .out_vld  (rot1_vld),
        .x_out    (rot1_x),
        .y_out    (rot1_y),
        .side_out (rot1_side_raw)
    );

    assign rot1_side = side_b_t'(rot1_side_raw);

    always_comb
    begin
        if (rot1_x[CW-1])
        begin
            along_c = '0;
        end
        else if (rot1_x > rot1_side.len)
        begin
            along_c = rot1_side.len;
        end
        else
        begin
            along_c = rot1_x;
        end
        sc_s_next = along_c + $signed({{(CW-REGW){1'b0}}, rot1_side.a.ld});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_s_reg    <= sc_s_next;
            sc_phi_reg  <= rot1_side.phi;
            sc_side_reg <= rot1_side.a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sc_valid_reg <= rot1_vld;
        end
    end

    // target point relative to segment start
    ppls_cordic_rot #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SA_W)
    ) u_rot_target (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sc_valid_reg),
        .x_in     (sc_s_reg),
        .y_in     ('0),
        .z_in     (sc_phi_reg),
        .side_in  (sc_side_reg),
        .out_vld  (rot2_vld),
        .x_out    (rot2_x),
        .y_out    (rot2_y),
        .side_out (rot2_side_raw)
    );

    assign rot2_side = side_a_t'(rot2_side_raw);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_wx_reg   <= rot2_x - CW'(rot2_side.vx);
            sd_wy_reg   <= rot2_y - CW'(rot2_side.vy);
            sd_side_reg <= rot2_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sd_valid_reg <= rot2_vld;
        end
    end

    always_comb
    begin
        vec2_side_in.speed = sd_side_reg.speed;
        vec2_side_in.hd    = sd_side_reg.hd;
        vec2_side_in.ld    = sd_side_reg.ld;
        vec2_side_in.degen = sd_side_reg.degen;
        vec2_side_in.wzero = (sd_wx_reg == '0) && (sd_wy_reg == '0);
    end

    // bearing to the target
    ppls_cordic_vec #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SC_W)
    ) u_vec_bearing (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sd_valid_reg),
        .x_in     (sd_wx_reg),
        .y_in     (sd_wy_reg),
        .side_in  (vec2_side_in),
        .out_vld  (vec2_vld),
        .mag      (vec2_mag),
        .ang      (vec2_ang),
        .side_out (vec2_side_raw)
    );

    assign vec2_side = side_c_t'(vec2_side_raw);

    // target on the robot means bearing zero; magnitude of the offset is not needed
    assign theta_c = (vec2_side.wzero || (vec2_mag == '0 && vec2_side.wzero)) ? '0 : vec2_ang;
    assign hd_q30  = ZW'(vec2_side.hd) <<< ANG_SHIFT;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            se_alpha_reg <= theta_c - hd_q30;
            se_side_reg  <= vec2_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            se_valid_reg <= vec2_vld;
        end
    end

    // heading spans about +-8 rad, so at most two turns come off
    assign alpha_m1 = se_alpha_reg - TWO_PI_Q30;
    assign alpha_m2 = se_alpha_reg - FOUR_PI_Q30;
    assign alpha_p1 = se_alpha_reg + TWO_PI_Q30;
    assign alpha_p2 = se_alpha_reg + FOUR_PI_Q30;

    always_comb
    begin
        if (se_alpha_reg > PI_Q30)
        begin
            alpha_w = (alpha_m1 > PI_Q30) ? alpha_m2 : alpha_m1;
        end
        else if (se_alpha_reg < -PI_Q30)
        begin
            alpha_w = (alpha_p1 < -PI_Q30) ? alpha_p2 : alpha_p1;
        end
        else
        begin
            alpha_w = se_alpha_reg;
        end
        sf_side_next.speed = se_side_reg.speed;
        sf_side_next.ld    = se_side_reg.ld;
        sf_side_next.degen = se_side_reg.degen;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sf_alpha_reg <= alpha_w;
            sf_side_reg  <= sf_side_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sf_valid_reg <= se_valid_reg;
        end
    end

    // sine of the heading error
    ppls_cordic_rot #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SD_W)
    ) u_rot_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sf_valid_reg),
        .x_in     (ONE_Q30),
        .y_in     ('0),
        .z_in     (sf_alpha_reg),
        .side_in  (sf_side_reg),
        .out_vld  (rot3_vld),
        .x_out    (rot3_x),
        .y_out    (rot3_y),
        .side_out (rot3_side_raw)
    );

    assign rot3_side = side_d_t'(rot3_side_raw);
    assign sn        = SNW'(rot3_y);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sg_m_reg    <= rot3_side.speed * sn;
            sg_tiny_reg <= (rot3_y < SIN_EPS_Q30) && (rot3_y > -SIN_EPS_Q30)
                           && (rot3_x == rot3_x);
            sg_neg_reg  <= rot3_side.speed[SPW-1] ^ sn[SNW-1];
            sg_side_reg <= rot3_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sg_valid_reg <= rot3_vld;
        end
    end

    // |2*speed*sin| >> 14 equals |speed*sin| >> 13; overflow when quotient needs > 32 bits
    assign m_abs   = sg_m_reg[MW-1] ? MW'(-sg_m_reg) : MW'(sg_m_reg);
    assign div_num = NUMW'(m_abs >> (ANG_SHIFT - 1));
    assign ovf     = REGW'(div_num[NUMW-1:QW]) >= sg_side_reg.ld;

    always_comb
    begin
        div_side_in.speed  = sg_side_reg.speed;
        div_side_in.degen  = sg_side_reg.degen;
        div_side_in.tiny   = sg_tiny_reg;
        div_side_in.ldz    = (sg_side_reg.ld == '0);
        div_side_in.speedz = (sg_side_reg.speed == '0);
        div_side_in.ovf    = ovf;
        div_side_in.neg    = sg_neg_reg;
    end

    ppls_divider #(
        .SIDE_W (SE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (sg_valid_reg),
        .num      (div_num),
        .den      (sg_side_reg.ld),
        .side_in  (div_side_in),
        .out_vld  (div_vld),
        .quo      (div_q),
        .side_out (div_side_raw)
    );

    assign div_side = side_e_t'(div_side_raw);

    // special cases, sign and saturation
    always_comb
    begin
        if (div_side.degen || div_side.tiny)
        begin
            rate_next = '0;
        end
        else if (div_side.ldz)
        begin
            rate_next = div_side.speedz ? '0 : (div_side.neg ? RATE_MIN : RATE_MAX);
        end
        else if (div_side.ovf)
        begin
            rate_next = div_side.neg ? RATE_MIN : RATE_MAX;
        end
        else if (div_side.neg)
        begin
            rate_next = (div_q > QW'(RATE_MIN)) ? RATE_MIN : -$signed(div_q);
        end
        else
        begin
            rate_next = div_q[QW-1] ? RATE_MAX : $signed(div_q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_out_reg <= div_side.speed;
            turn_rate_reg <= rate_next;
            degen_reg     <= div_side.degen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld;
        end
    end

    assign out_valid          = out_valid_reg;
    assign speed_out          = speed_out_reg;
    assign turn_rate          = turn_rate_reg;
    assign degenerate_segment = degen_reg;

`ifndef ASSERT_OFF
    // a zero-length segment never steers
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate_segment |-> turn_rate == '0)
        else $error("degenerate segment with nonzero turn rate");

    // a held result freezes the head of the pipeline
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(s0_valid_reg) && $stable(s0_dx_reg))
        else $error("pipeline moved while the result was stalled");

    // minimum lookahead write lands
    a_cfg_min: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == REG_MIN |=> min_reg == $past(cfg_data))
        else $error("lookahead minimum write lost");
`endif

endmodule

### tb/pure_pursuit_line_steering_top_test.sv
// testbench for the pure-pursuit line steering pipeline
`timescale 1ns / 1ps

module pure_pursuit_line_steering_top_test;
    import ppls_pkg::*;

    localparam int STAGES    = 16;
    localparam int LATENCY   = 5 * STAGES + 55;
    localparam int WDOG_MAX  = 20000;

    // index with no register behind it
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic signed [SPW-1:0] speed;
        logic signed [PW-1:0]  turn_rate;
        logic                  degenerate;
    } steer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [SPW-1:0] speed;
    logic signed [PW-1:0]  pos_x, pos_y, start_x, start_y, end_x, end_y;
    logic signed [HDW-1:0] heading;
    logic out_valid;
    logic out_stall;
    logic signed [SPW-1:0] speed_out;
    logic signed [PW-1:0]  turn_rate;
    logic degenerate_segment;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [REGW-1:0] cfg_data;

    pure_pursuit_line_steering_top #(.CORDIC_STAGES(STAGES)) u_top (.*);

    // predictor's copy of the lookahead registers
    longint la_gain, la_min, la_max;

    steer_t expected_steer[$];
    int     errors;
    int     idle_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor shift, arithmetic on longint
    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_at(int i);
        return longint'(atan_q30(i));
    endfunction

    function automatic longint unscale(longint v);
        return fshr(v * 64'sd10187995 + (64'sd1 << 23), 24);
    endfunction

    task automatic vec_angle(input longint x, input longint y,
                             output longint mag, output longint ang);
        longint z, xs, ys;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += atan_at(i);
            end
            else
            begin
                x -= ys; y += xs; z -= atan_at(i);
            end
        end
        mag = unscale(x);
        ang = z;
    endtask

    task automatic rotate(input longint x, input longint y, input longint z,
                          output longint ox, output longint oy);
        longint xs, ys;
        while (z > longint'(HALF_PI_Q30))
        begin
            x = -x; y = -y; z -= longint'(PI_Q30);
        end
        while (z < -longint'(HALF_PI_Q30))
        begin
            x = -x; y = -y; z += longint'(PI_Q30);
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_at(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_at(i);
            end
        end
        ox = unscale(x);
        oy = unscale(y);
    endtask

    // steering command for one pose and segment
    task automatic predict_steer(input longint spd, px, py, hd, sx, sy, ex, ey,
                                 output steer_t r);
        longint p, ld, dx, dy, len, phi, vx, vy, along, perp, s, ux, uy;
        longint wx, wy, theta, alpha, c, sn, rate, num, den;
        r.speed = spd[SPW-1:0];
        r.degenerate = 1'b0;
        p = fshr(la_gain * spd, FRAC_BITS);
        if (p < la_min) ld = la_min;
        else if (p > la_max) ld = la_max;
        else ld = p;
        dx = ex - sx;
        dy = ey - sy;
        if (dx == 0 && dy == 0)
        begin
            r.turn_rate = '0;
            r.degenerate = 1'b1;
            return;
        end
        vec_angle(dx, dy, len, phi);
        vx = px - sx;
        vy = py - sy;
        rotate(vx, vy, -phi, along, perp);
        if (along < 0) along = 0;
        if (along > len) along = len;
        s = along + ld;
        rotate(s, 0, phi, ux, uy);
        wx = ux - vx;
        wy = uy - vy;
        // target right on the robot gives zero bearing
        if (wx == 0 && wy == 0) theta = 0;
        else vec_angle(wx, wy, c, theta);
        alpha = theta - hd * (64'sd1 <<< ANG_SHIFT);
        while (alpha > longint'(PI_Q30)) alpha -= longint'(TWO_PI_Q30);
        while (alpha < -longint'(PI_Q30)) alpha += longint'(TWO_PI_Q30);
        rotate(64'sd1 << 30, 0, alpha, c, sn);
        if (sn < 1074 && sn > -1074)
            rate = 0;
        else if (ld == 0)
        begin
            // zero lookahead saturates toward the sign of the command
            if (spd == 0) rate = 0;
            else if ((spd > 0) == (sn > 0)) rate = 64'sd2147483647;
            else rate = -64'sd2147483648;
        end
        else
        begin
            num = 2 * spd * sn;
            den = ld * (64'sd1 <<< ANG_SHIFT);
            rate = num / den;
            if (rate > 64'sd2147483647) rate = 64'sd2147483647;
            if (rate < -64'sd2147483648) rate = -64'sd2147483648;
        end
        r.turn_rate = rate[PW-1:0];
    endtask

    // one steering request, held until accepted
    task automatic send_pose(input logic signed [SPW-1:0] spd,
                             input logic signed [PW-1:0] px, py,
                             input logic signed [HDW-1:0] hd,
                             input logic signed [PW-1:0] sx, sy, ex, ey);
        steer_t r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        speed <= spd; pos_x <= px; pos_y <= py; heading <= hd;
        start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
        predict_steer(spd, px, py, hd, sx, sy, ex, ey, r);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_steer.push_back(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [REGW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN: la_gain = longint'(val);
            REG_MIN:  la_min = longint'(val);
            REG_MAX:  la_max = longint'(val);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_steer.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // random pose near a random segment, mostly small coordinates
    task automatic send_random_pose(input bit wide);
        logic signed [PW-1:0] sx, sy, ex, ey, px, py;
        logic signed [SPW-1:0] spd;
        logic signed [HDW-1:0] hd;
        spd = SPW'($urandom);
        hd = HDW'($urandom);
        if (wide || $urandom_range(9) == 0)
        begin
            sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
            px = $urandom; py = $urandom;
        end
        else
        begin
            sx = $signed($urandom_range(2000000)) - 1000000;
            sy = $signed($urandom_range(2000000)) - 1000000;
            ex = sx + $signed($urandom_range(1200000)) - 600000;
            ey = sy + $signed($urandom_range(1200000)) - 600000;
            px = sx + $signed($urandom_range(400000)) - 200000;
            py = sy + $signed($urandom_range(400000)) - 200000;
            if ($urandom_range(19) == 0)
            begin
                ex = sx; ey = sy;
            end
        end
        send_pose(spd, px, py, hd, sx, sy, ex, ey);
    endtask

    task automatic test_directed;
        send_pose(21'sd65536, 0, 0, 0, 0, 0, 32'sd655360, 0);
        send_pose(21'sd65536, 32'sd65536, 32'sd65536, 0, 32'sd65536, 32'sd65536,
                  32'sd65536, 32'sd65536);
        send_pose(-21'sd1048576, 0, 32'sd30000, 20'sd102944, 0, 0, 0, 32'sd655360);
        send_pose(21'sd1048575, 32'sh7fffffff, 32'sh80000000, 20'sd524287,
                  32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_pose(0, 0, 0, -20'sd524288, 0, 0, 32'sd1000, 32'sd1000);
        send_pose(21'sd65536, 32'sd900000, 0, 0, 0, 0, 32'sd655360, 0);
        send_pose(21'sd65536, -32'sd900000, 32'sd5, 0, 0, 0, 32'sd655360, 0);
        send_pose(21'sd100000, 0, 0, 20'sd205887, 0, 0, -32'sd655360, 0);
        send_pose(21'sd100000, 0, 0, -20'sd205887, 0, 0, 0, -32'sd655360);
        send_pose(21'sd1, 0, 0, 0, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff);
        drain();
    endtask

    task automatic test_registers;
        // zero lookahead, min above max, extremes, unused index
        write_reg(REG_GAIN, '0);
        write_reg(REG_MIN, '0);
        write_reg(REG_MAX, '0);
        write_reg(REG_NONE, 20'hABCDE);
        repeat (30) send_random_pose(1'b0);
        send_pose(0, 0, 0, 20'sd1000, 0, 0, 32'sd65536, 0);
        drain();
        write_reg(REG_GAIN, 20'hFFFFF);
        write_reg(REG_MIN, 20'hFFFFF);
        write_reg(REG_MAX, 20'h10000);
        repeat (30) send_random_pose(1'b0);
        drain();
        write_reg(REG_GAIN, 20'd65536);
        write_reg(REG_MIN, 20'd100);
        write_reg(REG_MAX, 20'hFFFFF);
        repeat (30) send_random_pose(1'b0);
        drain();
        write_reg(REG_GAIN, 20'd19661);
        write_reg(REG_MIN, 20'd19661);
        write_reg(REG_MAX, 20'd131072);
    endtask

    task automatic test_random(input int snd, input int rcv, input int n);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        repeat (n) send_random_pose($urandom_range(7) == 0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
    endtask

    task automatic test_backpressure;
        hold_off = 1'b1;
        repeat (400) send_random_pose(1'b0);
        drain();
    endtask

    // long receiver hold-off while requests keep coming
    initial
    begin
        int cnt;
        hold_off = 1'b0;
        wait (hold_off);
        cnt = 0;
        while (cnt < 600)
        begin
            @(posedge clk);
            cnt++;
        end
        hold_off = 1'b0;
    end

    always @(posedge clk)
        if (rst_n)
            out_stall <= hold_off ||
                (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        steer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_steer.size() == 0)
            begin
                $display("%0t: unexpected result rate %0d", $time, turn_rate);
                errors++;
            end
            else
            begin
                e = expected_steer.pop_front();
                if (speed_out !== e.speed)
                begin
                    $display("%0t: speed_out expected %0d actual %0d",
                             $time, e.speed, speed_out);
                    errors++;
                end
                if (turn_rate !== e.turn_rate)
                begin
                    $display("%0t: turn_rate expected %0d actual %0d",
                             $time, e.turn_rate, turn_rate);
                    errors++;
                end
                if (degenerate_segment !== e.degenerate)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, e.degenerate, degenerate_segment);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any acceptance
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        la_gain = 19661;
        la_min = 19661;
        la_max = 131072;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        speed = '0; pos_x = '0; pos_y = '0; heading = '0;
        start_x = '0; start_y = '0; end_x = '0; end_y = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_registers();
        test_random(0, 0, 150);
        test_random(84, 0, 120);
        test_random(0, 84, 120);
        test_random(27, 27, 150);
        test_backpressure();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
